>>> rtl/gbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer line editor package
// Shared constants, command and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package gbe_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHAR_W   = 8;
	localparam int ACT_W    = 3;
	localparam int STAT_W   = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_LEFT   = 3'd1,
		ACT_RIGHT  = 3'd2,
		ACT_BACK   = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_XFER = 1'b1
	} state_t;

endpackage

>>> rtl/gap_buffer_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer line editor
// A one-line text buffer with a cursor, kept as a gap buffer in one RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and its result
// appears on the output ports for exactly one cycle with done high; the
// receiver cannot stall it. Insert, backspace and every refused or ignored
// command finish without a transfer step, so the result shows in the cycle
// after start and the next command may follow at once. Cursor moves and
// in-range reads go through a transfer step, since the single RAM port
// first reads one entry, which a cursor move writes back across the gap;
// busy is high during that step. No clearing pass is needed after reset.
module gap_buffer_line_editor
	import gbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ACT_W-1:0]  action,
	input  logic [CHAR_W-1:0] ch,
	input  logic [ADDR_W-1:0] position,
	output logic              done,
	output logic [CHAR_W-1:0] read_char,
	output logic [CNT_W-1:0]  text_length,
	output logic [CNT_W-1:0]  cursor_pos,
	output logic [STAT_W-1:0] status
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  left_q, left_d;
	logic [CNT_W-1:0]  right_q, right_d;
	action_t           act_q, act_d;
	logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
	logic              go_xfer;

	logic              mem_en;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [CHAR_W-1:0] mem_wdata;
	logic [CHAR_W-1:0] mem_rdata;

	logic              res_load;
	logic [CHAR_W-1:0] res_char;
	status_t           res_status;

	logic              done_q;
	logic [CHAR_W-1:0] read_char_q;
	logic [CNT_W-1:0]  text_length_q;
	logic [CNT_W-1:0]  cursor_pos_q;
	status_t           status_q;

	logic [CNT_W-1:0]  used;
	logic [CNT_W-1:0]  gap_size;
	logic [CNT_W-1:0]  left_dec;
	logic [CNT_W-1:0]  right_top;
	logic [CNT_W-1:0]  right_first;
	action_t           act_in;

	assign act_in      = action_t'(action);
	assign used        = left_q + right_q;
	assign gap_size    = CNT_W'(CAPACITY) - used;
	assign left_dec    = left_q - CNT_W'(1);
	assign right_top   = CNT_W'(CAPACITY - 1) - right_q;
	assign right_first = CNT_W'(CAPACITY) - right_q;

	gbe_ram u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && go_xfer) begin
					state_d = S_XFER;
				end
			end
			S_XFER: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_en     = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = '0;
		mem_wdata  = ch;
		left_d     = left_q;
		right_d    = right_q;
		act_d      = act_q;
		wr_addr_d  = wr_addr_q;
		go_xfer    = 1'b0;
		res_load   = 1'b0;
		res_char   = '0;
		res_status = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				act_d = act_in;
				unique case (act_in)
					ACT_INSERT: begin
						res_load = start;
						if (used == CNT_W'(CAPACITY)) begin
							res_status = ST_FULL;
						end else begin
							mem_en   = start;
							mem_we   = 1'b1;
							mem_addr = left_q[ADDR_W-1:0];
							left_d   = start ? left_q + CNT_W'(1) : left_q;
						end
					end
					ACT_LEFT: begin
						if (left_q == '0) begin
							res_load   = start;
							res_status = ST_IGNORED;
						end else begin
							go_xfer   = 1'b1;
							mem_en    = start;
							mem_addr  = left_dec[ADDR_W-1:0];
							wr_addr_d = right_top[ADDR_W-1:0];
						end
					end
					ACT_RIGHT: begin
						if (right_q == '0) begin
							res_load   = start;
							res_status = ST_IGNORED;
						end else begin
							go_xfer   = 1'b1;
							mem_en    = start;
							mem_addr  = right_first[ADDR_W-1:0];
							wr_addr_d = left_q[ADDR_W-1:0];
						end
					end
					ACT_BACK: begin
						res_load = start;
						if (left_q == '0) begin
							res_status = ST_IGNORED;
						end else begin
							left_d = start ? left_dec : left_q;
						end
					end
					ACT_READ: begin
						if (CNT_W'(position) >= used) begin
							res_load   = start;
							res_status = ST_RANGE;
						end else begin
							go_xfer = 1'b1;
							mem_en  = start;
							if (CNT_W'(position) < left_q) begin
								mem_addr = position;
							end else begin
								mem_addr = position + gap_size[ADDR_W-1:0];
							end
						end
					end
					default: begin
						res_load   = start;
						res_status = ST_IGNORED;
					end
				endcase
			end
			S_XFER: begin
				res_load  = 1'b1;
				mem_wdata = mem_rdata;
				mem_addr  = wr_addr_q;
				if (act_q == ACT_READ) begin
					res_char = mem_rdata;
				end else begin
					mem_en = 1'b1;
					mem_we = 1'b1;
					if (act_q == ACT_LEFT) begin
						left_d  = left_dec;
						right_d = right_q + CNT_W'(1);
					end else begin
						left_d  = left_q + CNT_W'(1);
						right_d = right_q - CNT_W'(1);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q  <= '0;
			right_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			right_q <= right_d;
			done_q  <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			act_q     <= act_d;
			wr_addr_q <= wr_addr_d;
		end
		if (res_load) begin
			read_char_q   <= res_char;
			text_length_q <= left_d + right_d;
			cursor_pos_q  <= left_d;
			status_q      <= res_status;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign read_char   = read_char_q;
	assign text_length = text_length_q;
	assign cursor_pos  = cursor_pos_q;
	assign status      = status_q;

endmodule

>>> rtl/gbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer text store
// Single-port synchronous RAM holding the text, with a registered read.
// ----------------------------------------------------------------------------
module gbe_ram
	import gbe_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [CHAR_W-1:0] wdata,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [CAPACITY];
	logic [CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> tb/sv/gap_buffer_line_editor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer line editor testbench
// Drives insert, cursor, backspace, read and unused commands through the
// start/busy handshake in random bursts. It predicts each result from its own
// copy of the text and cursor, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor_tb;
	import gbe_pkg::*;

	typedef struct {
		logic [CHAR_W-1:0] read_char;
		logic [CNT_W-1:0]  text_length;
		logic [CNT_W-1:0]  cursor_pos;
		status_t           status;
	} editor_reply_t;

	class editor_scoreboard;
		logic [CHAR_W-1:0] text_mem [CAPACITY];
		int left_len;
		int right_len;
		editor_reply_t expected_replies[$];
		int failures;
		int commands;
		int replies;
		int peak_len;
		int status_count [4];

		function new();
			left_len = 0;
			right_len = 0;
			failures = 0;
			commands = 0;
			replies = 0;
			peak_len = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		function int text_len();
			return left_len + right_len;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function void note_command(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] c,
				logic [ADDR_W-1:0] pos);
			editor_reply_t r;
			int used;
			used = left_len + right_len;
			r.read_char = '0;
			r.status = ST_DONE;
			case (act)
				ACT_INSERT: begin
					if (used >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						text_mem[left_len] = c;
						left_len++;
					end
				end
				ACT_LEFT: begin
					if (left_len == 0) begin
						r.status = ST_IGNORED;
					end else begin
						text_mem[CAPACITY - 1 - right_len] = text_mem[left_len - 1];
						left_len--;
						right_len++;
					end
				end
				ACT_RIGHT: begin
					if (right_len == 0) begin
						r.status = ST_IGNORED;
					end else begin
						text_mem[left_len] = text_mem[CAPACITY - right_len];
						left_len++;
						right_len--;
					end
				end
				ACT_BACK: begin
					if (left_len == 0) r.status = ST_IGNORED;
					else left_len--;
				end
				ACT_READ: begin
					if (pos >= used) r.status = ST_RANGE;
					else if (pos < left_len) r.read_char = text_mem[pos];
					else r.read_char = text_mem[CAPACITY - right_len + (pos - left_len)];
				end
				default: r.status = ST_IGNORED;
			endcase
			r.text_length = CNT_W'(left_len + right_len);
			r.cursor_pos = CNT_W'(left_len);
			expected_replies = {expected_replies, r};
			commands++;
			status_count[r.status]++;
			if (left_len + right_len > peak_len) peak_len = left_len + right_len;
		endfunction

		function void check_result(logic [CHAR_W-1:0] rc, logic [CNT_W-1:0] len,
				logic [CNT_W-1:0] cur, logic [STAT_W-1:0] st);
			editor_reply_t r;
			replies++;
			if (expected_replies.size() == 0) begin
				failures++;
				$error("result with no command outstanding");
				return;
			end
			r = expected_replies.pop_front();
			if (rc !== r.read_char) begin
				failures++;
				$error("read_char: expected %0h, actual %0h", r.read_char, rc);
			end
			if (len !== r.text_length) begin
				failures++;
				$error("text_length: expected %0d, actual %0d", r.text_length, len);
			end
			if (cur !== r.cursor_pos) begin
				failures++;
				$error("cursor_pos: expected %0d, actual %0d", r.cursor_pos, cur);
			end
			if (st !== r.status) begin
				failures++;
				$error("status: expected %0d, actual %0d", r.status, st);
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [ACT_W-1:0]  action = '0;
	logic [CHAR_W-1:0] ch = '0;
	logic [ADDR_W-1:0] position = '0;
	logic              done;
	logic [CHAR_W-1:0] read_char;
	logic [CNT_W-1:0]  text_length;
	logic [CNT_W-1:0]  cursor_pos;
	logic [STAT_W-1:0] status;

	editor_scoreboard sb = new();
	int burst_left = 0;
	int stall_cycles = 0;
	int last_progress = 0;

	gap_buffer_line_editor uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.ch(ch),
		.position(position),
		.done(done),
		.read_char(read_char),
		.text_length(text_length),
		.cursor_pos(cursor_pos),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic issue(input logic [ACT_W-1:0] a, input logic [CHAR_W-1:0] c,
			input logic [ADDR_W-1:0] p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start <= 1'b1;
		action <= a;
		ch <= c;
		position <= p;
		do @(posedge clk); while (busy);
		sb.note_command(a, c, p);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic random_command(input int insert_pct);
		int pick;
		int len;
		logic [ADDR_W-1:0] p;
		pick = $urandom_range(0, 99);
		len = sb.text_len();
		p = ADDR_W'($urandom_range(0, CAPACITY - 1));
		if (pick < insert_pct) begin
			issue(ACT_INSERT, CHAR_W'($urandom_range(0, 255)), p);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				issue(ACT_LEFT, CHAR_W'($urandom_range(0, 255)), p);
			end else if (pick < 50) begin
				issue(ACT_RIGHT, CHAR_W'($urandom_range(0, 255)), p);
			end else if (pick < 65) begin
				issue(ACT_BACK, CHAR_W'($urandom_range(0, 255)), p);
			end else if (pick < 95) begin
				if (len > 0 && $urandom_range(0, 9) < 7) p = ADDR_W'($urandom_range(0, len - 1));
				issue(ACT_READ, CHAR_W'($urandom_range(0, 255)), p);
			end else begin
				issue(ACT_W'($urandom_range(5, 7)), CHAR_W'($urandom_range(0, 255)), p);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(read_char, text_length, cursor_pos, status);
	end

	always @(posedge clk) begin
		if (sb.commands + sb.replies != last_progress || !arst_n) begin
			last_progress = sb.commands + sb.replies;
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$error("no word moved for %0d cycles", STALL_LIMIT);
				$display("gap_buffer_line_editor: mismatch");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Edge cases on an empty line, unused codes, then a short text walked end to end.
		issue(ACT_LEFT, 8'h00, '0);
		issue(ACT_RIGHT, 8'h00, '0);
		issue(ACT_BACK, 8'h00, '0);
		issue(ACT_READ, 8'h00, '0);
		issue(ACT_READ, 8'h00, '1);
		issue(3'd5, 8'hFF, '1);
		issue(3'd6, 8'h00, '0);
		issue(3'd7, 8'hFF, '1);
		issue(ACT_INSERT, 8'h00, '0);
		issue(ACT_INSERT, 8'hFF, '1);
		issue(ACT_INSERT, 8'h5A, '0);
		issue(ACT_READ, 8'h00, 10'd0);
		issue(ACT_READ, 8'h00, 10'd2);
		issue(ACT_READ, 8'h00, 10'd3);
		repeat (4) issue(ACT_LEFT, 8'h00, '0);
		issue(ACT_READ, 8'h00, 10'd1);
		repeat (4) issue(ACT_RIGHT, 8'h00, '0);
		issue(ACT_BACK, 8'h00, '0);
		drain();

		repeat (50) random_command(40);
		drain();

		// Mostly inserts until the line is full and refusals have been seen.
		while (sb.status_count[ST_FULL] < 12) random_command(97);

		repeat (40) random_command(20);
		drain();
		repeat (10) @(posedge clk);

		$display("Ran %0d commands and checked %0d results; longest line %0d characters.",
			sb.commands, sb.replies, sb.peak_len);
		$display("Statuses seen: done %0d, ignored %0d, full %0d, out of range %0d.",
			sb.status_count[ST_DONE], sb.status_count[ST_IGNORED],
			sb.status_count[ST_FULL], sb.status_count[ST_RANGE]);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("gap_buffer_line_editor: match");
		end else begin
			$display("gap_buffer_line_editor: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/gbe_pkg.sv
rtl/gbe_ram.sv
rtl/gap_buffer_line_editor.sv
tb/sv/gap_buffer_line_editor_tb.sv
